// ===== rtl/abb_pkg.sv =====
// Shared types, widths and register codes for the absorbing boundary blend block.
package abb_pkg;

    // Field widths
    localparam int IDX_W      = 10;
    localparam int SAMPLE_W   = 16;
    localparam int W_W        = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Weight fixed point: unsigned Q1.15
    localparam int               W_FRAC = 15;
    localparam logic [W_W-1:0]   W_ONE  = W_W'(1 << W_FRAC);

    // Ratio datapath widths
    localparam int PROD2_W = 2 * IDX_W;          // product of two ramp widths
    localparam int PROD3_W = 3 * IDX_W;          // product of three ramp widths
    localparam int DEN_W   = PROD3_W + 2;        // 3 * lx * ly * lz
    localparam int NUM_W   = DEN_W + 1;          // 2 * sum of cross terms
    localparam int QUO_W   = W_FRAC + 1;         // quotient bits, one below weight LSB

    // Configuration register codes
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

    // Reset values of the bounds
    localparam logic [IDX_W-1:0] LOW_RESET  = '0;
    localparam logic [IDX_W-1:0] HIGH_RESET = '1;

    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } bounds_t;

    typedef struct packed {
        bounds_t x;
        bounds_t y;
        bounds_t z;
    } cfg_t;

    // Both complex samples of one grid point
    typedef struct packed {
        sample_t rt_re;
        sample_t rt_im;
        sample_t it_re;
        sample_t it_im;
    } samples_t;

    // Ratio handed from the front end to the divider
    typedef struct packed {
        logic             sat;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } ratio_t;

    // Quotient handed from the divider to the mixer
    typedef struct packed {
        logic             sat;
        logic [QUO_W-1:0] quo;
    } quo_t;

endpackage

// ===== rtl/abb_if.sv =====
// Valid/ready channel interfaces for grid point input and blended output.
interface abb_in_if import abb_pkg::*; ();
    logic    valid;
    logic    ready;
    idx_t    x_index;
    idx_t    y_index;
    idx_t    z_index;
    sample_t realtime_re;
    sample_t realtime_im;
    sample_t imagtime_re;
    sample_t imagtime_im;

    modport source (
        output valid, x_index, y_index, z_index,
        output realtime_re, realtime_im, imagtime_re, imagtime_im,
        input  ready
    );
    modport sink (
        input  valid, x_index, y_index, z_index,
        input  realtime_re, realtime_im, imagtime_re, imagtime_im,
        output ready
    );
endinterface

interface abb_out_if import abb_pkg::*; ();
    logic           valid;
    logic           ready;
    sample_t        blend_re;
    sample_t        blend_im;
    logic [W_W-1:0] weight;

    modport source (
        output valid, blend_re, blend_im, weight,
        input  ready
    );
    modport sink (
        input  valid, blend_re, blend_im, weight,
        output ready
    );
endinterface

// ===== rtl/abb_front.sv =====
// Front end: per-axis ramp distances, cross products and the weight ratio (five stages).
module abb_front import abb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  cfg_t     cfg,
    input  logic     in_valid,
    input  idx_t     x_index,
    input  idx_t     y_index,
    input  idx_t     z_index,
    input  samples_t in_smp,
    output logic     out_valid,
    output ratio_t   out_ratio,
    output samples_t out_smp
);

    typedef struct packed {
        logic active;
        idx_t depth;
        idx_t div;
    } axis_t;

    // Distance into the ramp; the high side also divides by the low bound
    function automatic axis_t axis_term(idx_t idx, bounds_t b);
        axis_t a;
        if (idx < b.lo)
        begin
            a.active = 1'b1;
            a.depth  = b.lo - idx;
            a.div    = b.lo;
        end
        else if (idx > b.hi)
        begin
            a.active = 1'b1;
            a.depth  = idx - b.hi;
            a.div    = b.lo;
        end
        else
        begin
            a.active = 1'b0;
            a.depth  = '0;
            a.div    = IDX_W'(1);
        end
        return a;
    endfunction

    axis_t ax, ay, az;
    assign ax = axis_term(x_index, cfg.x);
    assign ay = axis_term(y_index, cfg.y);
    assign az = axis_term(z_index, cfg.z);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    // Stage 1: axis terms, zero divisor flag
    idx_t     s1_dx_reg, s1_dy_reg, s1_dz_reg;
    idx_t     s1_lx_reg, s1_ly_reg, s1_lz_reg;
    logic     s1_sat_reg;
    samples_t s1_smp_reg;

    // Stage 2: pairwise ramp products
    idx_t               s2_dx_reg, s2_dy_reg, s2_dz_reg, s2_lz_reg;
    logic [PROD2_W-1:0] s2_pxy_reg, s2_pxz_reg, s2_pyz_reg;
    logic               s2_sat_reg;
    samples_t           s2_smp_reg;

    // Stage 3: cross terms and triple product
    logic [PROD3_W-1:0] s3_tx_reg, s3_ty_reg, s3_tz_reg, s3_den_reg;
    logic               s3_sat_reg;
    samples_t           s3_smp_reg;

    // Stage 4: numerator and denominator
    logic [NUM_W-1:0] s4_num_reg;
    logic [DEN_W-1:0] s4_den_reg;
    logic             s4_sat_reg;
    samples_t         s4_smp_reg;

    // Stage 5: saturation compare
    ratio_t   s5_ratio_reg;
    samples_t s5_smp_reg;

    logic [DEN_W-1:0] tsum_next;
    logic [DEN_W-1:0] den_next;
    logic             over_next;

    assign tsum_next = DEN_W'(s3_tx_reg) + DEN_W'(s3_ty_reg) + DEN_W'(s3_tz_reg);
    assign den_next  = DEN_W'({s3_den_reg, 1'b0}) + DEN_W'(s3_den_reg);
    assign over_next = s4_num_reg >= {1'b0, s4_den_reg};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= ax.depth;
            s1_dy_reg  <= ay.depth;
            s1_dz_reg  <= az.depth;
            s1_lx_reg  <= ax.div;
            s1_ly_reg  <= ay.div;
            s1_lz_reg  <= az.div;
            s1_sat_reg <= (ax.active && ax.div == '0) || (ay.active && ay.div == '0) ||
                          (az.active && az.div == '0);
            s1_smp_reg <= in_smp;

            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_dz_reg  <= s1_dz_reg;
            s2_lz_reg  <= s1_lz_reg;
            s2_pxy_reg <= PROD2_W'(s1_lx_reg) * PROD2_W'(s1_ly_reg);
            s2_pxz_reg <= PROD2_W'(s1_lx_reg) * PROD2_W'(s1_lz_reg);
            s2_pyz_reg <= PROD2_W'(s1_ly_reg) * PROD2_W'(s1_lz_reg);
            s2_sat_reg <= s1_sat_reg;
            s2_smp_reg <= s1_smp_reg;

            s3_tx_reg  <= PROD3_W'(s2_dx_reg) * PROD3_W'(s2_pyz_reg);
            s3_ty_reg  <= PROD3_W'(s2_dy_reg) * PROD3_W'(s2_pxz_reg);
            s3_tz_reg  <= PROD3_W'(s2_dz_reg) * PROD3_W'(s2_pxy_reg);
            s3_den_reg <= PROD3_W'(s2_lz_reg) * PROD3_W'(s2_pxy_reg);
            s3_sat_reg <= s2_sat_reg;
            s3_smp_reg <= s2_smp_reg;

            s4_num_reg <= {tsum_next, 1'b0};
            s4_den_reg <= den_next;
            s4_sat_reg <= s3_sat_reg;
            s4_smp_reg <= s3_smp_reg;

            // Ratio of one or more saturates; the divider then sees zero
            s5_ratio_reg.sat <= s4_sat_reg || over_next;
            s5_ratio_reg.num <= (s4_sat_reg || over_next) ? '0 : s4_num_reg[DEN_W-1:0];
            s5_ratio_reg.den <= s4_den_reg;
            s5_smp_reg       <= s4_smp_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_ratio = s5_ratio_reg;
    assign out_smp   = s5_smp_reg;

endmodule

// ===== rtl/abb_div.sv =====
// Pipelined restoring divider: one quotient bit of num * 2^16 / den per stage.
module abb_div import abb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  ratio_t   in_ratio,
    input  samples_t in_smp,
    output logic     out_valid,
    output quo_t     out_quo,
    output samples_t out_smp
);

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] rem_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic             sat_reg   [QUO_W];
    samples_t         smp_reg   [QUO_W];

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_stage
        logic             valid_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic             sat_in;
        samples_t         smp_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             take;

        if (g == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_ratio.num;
            assign den_in   = in_ratio.den;
            assign quo_in   = '0;
            assign sat_in   = in_ratio.sat;
            assign smp_in   = in_smp;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[g-1];
            assign rem_in   = rem_reg[g-1];
            assign den_in   = den_reg[g-1];
            assign quo_in   = quo_reg[g-1];
            assign sat_in   = sat_reg[g-1];
            assign smp_in   = smp_reg[g-1];
        end

        // Trial subtract of the doubled remainder
        assign shifted = {rem_in, 1'b0};
        assign diff    = shifted - {1'b0, den_in};
        assign take    = shifted >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[g] <= den_in;
                quo_reg[g] <= {quo_in[QUO_W-2:0], take};
                sat_reg[g] <= sat_in;
                smp_reg[g] <= smp_in;
            end
        end
    end

    assign out_valid   = valid_reg[QUO_W-1];
    assign out_quo.sat = sat_reg[QUO_W-1];
    assign out_quo.quo = quo_reg[QUO_W-1];
    assign out_smp     = smp_reg[QUO_W-1];

endmodule

// ===== rtl/abb_mix.sv =====
// Mixer: rounds the weight, then forms rt + w * (it - rt) per component (three stages).
module abb_mix import abb_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  quo_t           in_quo,
    input  samples_t       in_smp,
    output logic           out_valid,
    output sample_t        blend_re,
    output sample_t        blend_im,
    output logic [W_W-1:0] weight
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + W_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - W_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (W_FRAC - 1));
    localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   Q_MIN      = -Q_MAX - Q_W'(1);

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    logic m1_valid_reg, m2_valid_reg, m3_valid_reg;

    // Stage 1: weight and sample differences
    logic [W_W-1:0] m1_w_reg;
    diff_t          m1_dre_reg, m1_dim_reg;
    sample_t        m1_rre_reg, m1_rim_reg;

    // Stage 2: products
    logic [W_W-1:0] m2_w_reg;
    prod_t          m2_pre_reg, m2_pim_reg;
    sample_t        m2_rre_reg, m2_rim_reg;

    // Stage 3: output register
    logic [W_W-1:0] m3_w_reg;
    sample_t        m3_re_reg, m3_im_reg;

    logic [QUO_W:0] quo_inc;
    logic [W_W-1:0] w_next;
    acc_t           acc_re, acc_im;
    logic signed [Q_W-1:0] q_re, q_im;
    sample_t        sat_re, sat_im;

    // Nearest rounding, ties up: (q + 1) / 2
    assign quo_inc = {1'b0, in_quo.quo} + (QUO_W+1)'(1);
    assign w_next  = in_quo.sat ? W_ONE : W_W'(quo_inc >> 1);

    // rt * 2^15 + w * (it - rt) + half, floor-shifted back
    assign acc_re = (acc_t'(m2_rre_reg) <<< W_FRAC) + acc_t'(m2_pre_reg) + ROUND_HALF;
    assign acc_im = (acc_t'(m2_rim_reg) <<< W_FRAC) + acc_t'(m2_pim_reg) + ROUND_HALF;
    assign q_re   = acc_re[ACC_W-1:W_FRAC];
    assign q_im   = acc_im[ACC_W-1:W_FRAC];

    always_comb
    begin
        if (q_re > Q_MAX)
            sat_re = Q_MAX[SAMPLE_W-1:0];
        else if (q_re < Q_MIN)
            sat_re = Q_MIN[SAMPLE_W-1:0];
        else
            sat_re = q_re[SAMPLE_W-1:0];

        if (q_im > Q_MAX)
            sat_im = Q_MAX[SAMPLE_W-1:0];
        else if (q_im < Q_MIN)
            sat_im = Q_MIN[SAMPLE_W-1:0];
        else
            sat_im = q_im[SAMPLE_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_w_reg   <= w_next;
            m1_dre_reg <= diff_t'(in_smp.it_re) - diff_t'(in_smp.rt_re);
            m1_dim_reg <= diff_t'(in_smp.it_im) - diff_t'(in_smp.rt_im);
            m1_rre_reg <= in_smp.rt_re;
            m1_rim_reg <= in_smp.rt_im;

            m2_w_reg   <= m1_w_reg;
            m2_pre_reg <= prod_t'($signed({1'b0, m1_w_reg})) * prod_t'(m1_dre_reg);
            m2_pim_reg <= prod_t'($signed({1'b0, m1_w_reg})) * prod_t'(m1_dim_reg);
            m2_rre_reg <= m1_rre_reg;
            m2_rim_reg <= m1_rim_reg;

            m3_w_reg  <= m2_w_reg;
            m3_re_reg <= sat_re;
            m3_im_reg <= sat_im;
        end
    end

    assign out_valid = m3_valid_reg;
    assign blend_re  = m3_re_reg;
    assign blend_im  = m3_im_reg;
    assign weight    = m3_w_reg;

endmodule

// ===== rtl/absorbing_boundary_blend.sv =====
// Top level: bound registers, pipeline flow control and the three datapath sections.
// Pipeline: 5 front, 16 divider and 3 mixer stages lie between input beat and output beat.
// Throughput: one beat per cycle while the output is not back-pressured; the 16-stage quotient pipeline sets the depth.
// Back-pressure stalls every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits; low bounds reset to 0 and high bounds to 1023.
module absorbing_boundary_blend import abb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    abb_in_if.sink                in_ch,
    abb_out_if.source             out_ch,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    // Bound registers; writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x.lo <= LOW_RESET;
            cfg_reg.x.hi <= HIGH_RESET;
            cfg_reg.y.lo <= LOW_RESET;
            cfg_reg.y.hi <= HIGH_RESET;
            cfg_reg.z.lo <= LOW_RESET;
            cfg_reg.z.hi <= HIGH_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_X_LOW:  cfg_reg.x.lo <= cfg_data;
                REG_X_HIGH: cfg_reg.x.hi <= cfg_data;
                REG_Y_LOW:  cfg_reg.y.lo <= cfg_data;
                REG_Y_HIGH: cfg_reg.y.hi <= cfg_data;
                REG_Z_LOW:  cfg_reg.z.lo <= cfg_data;
                REG_Z_HIGH: cfg_reg.z.hi <= cfg_data;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Whole pipeline advances unless the output register holds an untaken beat
    logic en;
    logic out_valid;
    assign en           = !out_valid || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = out_valid;

    samples_t in_smp;
    assign in_smp.rt_re = in_ch.realtime_re;
    assign in_smp.rt_im = in_ch.realtime_im;
    assign in_smp.it_re = in_ch.imagtime_re;
    assign in_smp.it_im = in_ch.imagtime_im;

    logic     front_valid;
    ratio_t   front_ratio;
    samples_t front_smp;

    abb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .x_index   (in_ch.x_index),
        .y_index   (in_ch.y_index),
        .z_index   (in_ch.z_index),
        .in_smp    (in_smp),
        .out_valid (front_valid),
        .out_ratio (front_ratio),
        .out_smp   (front_smp)
    );

    logic     div_valid;
    quo_t     div_quo;
    samples_t div_smp;

    abb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_ratio  (front_ratio),
        .in_smp    (front_smp),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_smp   (div_smp)
    );

    abb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_quo    (div_quo),
        .in_smp    (div_smp),
        .out_valid (out_valid),
        .blend_re  (out_ch.blend_re),
        .blend_im  (out_ch.blend_im),
        .weight    (out_ch.weight)
    );

`ifndef SYNTHESIS
    // Weight never exceeds one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.weight <= W_ONE)
        else $error("weight above one");

    // Input is refused only when a finished beat waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled without output back-pressure");

    // Divider only sees proper fractions
    a_div_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ratio.sat) |-> front_ratio.num < front_ratio.den)
        else $error("divider input ratio not below one");
`endif

endmodule
